// ===== hdl/rkbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkbc_pkg: shared definitions for the repeating-key byte cipher
// Key store geometry, operation codes and the mod-255 byte arithmetic.
// ----------------------------------------------------------------------------
package rkbc_pkg;

  // Key store geometry
  localparam int KEY_DEPTH = 64;
  localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KEY_LW    = $clog2(KEY_DEPTH + 1);

  // Field widths
  localparam int BYTE_W = 8;
  localparam int OP_W   = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCRYPT = 2'd1;
  localparam logic [OP_W-1:0] OP_DECRYPT = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

  // Modulus of the byte arithmetic
  localparam logic [BYTE_W:0] BYTE_MOD = 9'd255;

  // Add or subtract one key byte, folding the result back into 1..255
  function automatic logic [BYTE_W-1:0] rkbc_cipher(
    input logic [BYTE_W-1:0] d,
    input logic [BYTE_W-1:0] k,
    input logic              enc
  );
    logic [BYTE_W:0] acc;
    acc = '0;
    if (enc) begin
      acc = {1'b0, d} + {1'b0, k};
      if (acc > {1'b0, 8'hFF}) begin
        acc = acc - BYTE_MOD;
      end
    end else begin
      if (d <= k) begin
        acc = {1'b0, d} + BYTE_MOD - {1'b0, k};
      end else begin
        acc = {1'b0, d} - {1'b0, k};
      end
    end
    return acc[BYTE_W-1:0];
  endfunction

endpackage

// ===== hdl/rkbc_key_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkbc_key_ram: key store memory
// One write port and one read port; read data is registered and holds while
// the read enable is low.
// ----------------------------------------------------------------------------
module rkbc_key_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry, hold the last value otherwise
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/repeating_key_byte_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeating_key_byte_cipher: repeating-key byte cipher over 1..255
// Loads a key into a store and encrypts or decrypts a byte stream with it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item per accepted edge:
//   an operation, a byte and a last flag. A load item writes the next key
//   byte; a load item with last set fixes the key length and rewinds the key
//   position. Encrypt and decrypt items each give one result item on the
//   output channel (out_valid / out_stall); load and unused codes give none.
//   An accepted item passes through the middle stage, where the synchronous
//   key store read completes, and then the output register, which takes the
//   add or subtract result. Throughput is one item per cycle while the
//   receiver does not stall, set by the single key store read port and
//   the arithmetic stage ahead of the output register.
//   When the receiver stalls, the output register holds its item; the middle
//   stage then fills and in_stall rises in the same cycle, so no item is lost.
//   Reset clears the key length, key position, load position and all valid
//   flags. The key store itself is not cleared; only loaded entries affect results.
// ----------------------------------------------------------------------------
module repeating_key_byte_cipher
  import rkbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_result_byte,
  output logic              out_last_out
);

  // Key state
  logic [KEY_LW-1:0] key_length_r, key_length_nxt;
  logic [KEY_AW-1:0] key_position_r, key_position_nxt;
  logic [KEY_LW-1:0] load_position_r, load_position_nxt;

  // Middle stage (key read in flight)
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_enc_r;
  logic              s1_bypass_r;
  logic [BYTE_W-1:0] s1_data_r;
  logic              s1_last_r;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_result_r;
  logic              out_last_r;

  // Handshake and decode
  logic              accept;
  logic              is_load;
  logic              is_data;
  logic              out_free;
  logic              s1_ready;
  logic              s1_move;
  logic              load_ok;
  logic [KEY_LW-1:0] load_inc;
  logic [KEY_LW-1:0] pos_inc;
  logic              pos_wrap;
  logic              ram_wr_en;
  logic [BYTE_W-1:0] key_byte;
  logic [BYTE_W-1:0] s1_result;

  assign is_load  = (in_operation == OP_LOAD);
  assign is_data  = (in_operation == OP_ENCRYPT) || (in_operation == OP_DECRYPT);
  assign out_free = !out_valid_r || !out_stall;
  assign s1_ready = !s1_valid_r || out_free;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = !s1_ready;
  assign accept   = in_valid && s1_ready;

  // Step the load and key positions
  assign load_ok   = (load_position_r < KEY_LW'(KEY_DEPTH));
  assign load_inc  = load_position_r + KEY_LW'(1);
  assign pos_inc   = KEY_LW'(key_position_r) + KEY_LW'(1);
  assign pos_wrap  = in_last || (pos_inc >= key_length_r);
  assign ram_wr_en = accept && is_load && load_ok;

  always_comb begin
    key_length_nxt    = key_length_r;
    key_position_nxt  = key_position_r;
    load_position_nxt = load_position_r;
    if (accept) begin
      case (in_operation)
        OP_LOAD: begin
          if (in_last) begin
            key_length_nxt    = load_ok ? load_inc : load_position_r;
            load_position_nxt = '0;
            key_position_nxt  = '0;
          end else if (load_ok) begin
            load_position_nxt = load_inc;
          end
        end
        OP_ENCRYPT, OP_DECRYPT: begin
          key_position_nxt = pos_wrap ? '0 : pos_inc[KEY_AW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Key store: write on load, read at the key position on data items
  rkbc_key_ram #(
    .DEPTH (KEY_DEPTH),
    .WIDTH (BYTE_W)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (load_position_r[KEY_AW-1:0]),
    .wr_data (in_data_byte),
    .rd_en   (accept && is_data),
    .rd_addr (key_position_r),
    .rd_data (key_byte)
  );

  // Advance the middle stage
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_ready) begin
      s1_valid_nxt = accept && is_data;
    end
  end

  // Apply the key byte
  assign s1_result = s1_bypass_r ? s1_data_r : rkbc_cipher(s1_data_r, key_byte, s1_enc_r);

  // Load or drop the output item
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s1_move;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r    <= '0;
      key_position_r  <= '0;
      load_position_r <= '0;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      key_length_r    <= key_length_nxt;
      key_position_r  <= key_position_nxt;
      load_position_r <= load_position_nxt;
      s1_valid_r      <= s1_valid_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_enc_r    <= (in_operation == OP_ENCRYPT);
      s1_bypass_r <= (key_length_r == '0);
      s1_data_r   <= in_data_byte;
      s1_last_r   <= in_last;
    end
    if (s1_move) begin
      out_result_r <= s1_result;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_byte = out_result_r;
  assign out_last_out    = out_last_r;

`ifndef SYNTHESIS
  // A full middle stage behind a stalled output must stall the input
  a_stall_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("middle stage overrun while output stalled");

  // The key position stays inside the loaded key
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (key_length_r == '0) || (KEY_LW'(key_position_r) < key_length_r))
    else $error("key position outside key length");

  // A final key byte rewinds both positions
  a_load_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_operation == OP_LOAD && in_last)
      |=> (key_position_r == '0 && load_position_r == '0 && key_length_r != '0))
    else $error("final key byte did not rewind positions");

  // A data item sits in the middle stage in the cycle after acceptance
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_operation == OP_ENCRYPT || in_operation == OP_DECRYPT))
      |=> s1_valid_r)
    else $error("data item lost in middle stage");
`endif

endmodule
